@@ sv/bdq_pkg.sv @@
// shared types, codes and constants of the bounded deque with value purge
package bdq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PURGE      = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic take_req;     // latch request, arm purge walk
        logic simple_done;  // finish a one-step request into the output register
        logic pop_read;     // read the slot a pop takes
        logic pop_done;     // finish a pop with the read data
        logic purge_read;   // read the next held entry
        logic purge_cmp;    // compare last read entry, keep or drop it
        logic purge_done;   // finish a purge
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            purge_more;
        logic            out_free;
    } t_stat;

endpackage

@@ sv/bdq_req_if.sv @@
// request channel: operation and value
interface bdq_req_if;
    logic                                      valid;
    logic                                      ready;
    logic        [bdq_pkg::OP_W-1:0]           operation;
    logic signed [bdq_pkg::DATA_W-1:0]         value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ sv/bdq_rsp_if.sv @@
// result channel: popped value, status, count after and removed count
interface bdq_rsp_if #(
    parameter int CNT_W = 7
);
    logic                                valid;
    logic                                ready;
    logic signed [bdq_pkg::DATA_W-1:0]   popped_value;
    logic        [bdq_pkg::STATUS_W-1:0] status;
    logic        [CNT_W-1:0]             count_after;
    logic        [CNT_W-1:0]             removed_count;

    modport source (output valid, output popped_value, output status,
                    output count_after, output removed_count, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input count_after, input removed_count, output ready);
endinterface

@@ sv/bounded_deque_with_value_purge_core.sv @@
// top level of the bounded deque with value purge
//
//  channel  | dir | payload                                           | handshake
//  ---------+-----+---------------------------------------------------+------------
//  i_req    | in  | operation[2:0], value[31:0] signed                | valid/ready
//  o_rsp    | out | popped_value, status, count_after, removed_count  | valid/ready
//
// pushes, clear, unused codes, failed pops and empty purges finish from the latched
// request; a pop first reads its slot: the ring memory has one write and one
// registered read port. a purge walks the held entries one per cycle through it.
// reset clears control state only; payload and memory stay undefined until written.
// a new request is taken while a result waits in the output register; a request
// finishes into that register only once it is free, and holds there until then.
module bounded_deque_with_value_purge_core #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_req_if.sink   i_req,
    bdq_rsp_if.source o_rsp
);

    bdq_pkg::t_cmd  w_cmd;
    bdq_pkg::t_stat w_stat;
    logic           w_req_ready;
    logic           w_load;

    // controller
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_req_ready (w_req_ready)
    );

    // datapath
    bdq_dpath #(
        .DEPTH (DEPTH),
        .IDX_W ($clog2(DEPTH)),
        .CNT_W (CNT_W)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_operation     (i_req.operation),
        .i_value         (i_req.value),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_popped_value  (o_rsp.popped_value),
        .o_status        (o_rsp.status),
        .o_count_after   (o_rsp.count_after),
        .o_removed_count (o_rsp.removed_count)
    );

    assign i_req.ready = w_req_ready;
    assign w_load      = w_cmd.simple_done | w_cmd.pop_done | w_cmd.purge_done;

    // a taken request keeps the block busy in the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous request still at work");

    // a result is only written into a free output register
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result overwrote a waiting result");

    // a full push reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == bdq_pkg::ST_FULL)
            |-> (o_rsp.count_after == CNT_W'(DEPTH)))
        else $error("full status with count below depth");

    // an empty pop reports an empty queue and no value
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == bdq_pkg::ST_EMPTY)
            |-> (o_rsp.count_after == '0 && o_rsp.popped_value == '0))
        else $error("empty status with entries held or a value popped");

endmodule

@@ sv/bdq_ctrl.sv @@
// controller state machine of the deque: sequences one request at a time
module bdq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  bdq_pkg::t_stat i_stat,
    output bdq_pkg::t_cmd  o_cmd,
    output logic           o_req_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_DATA,
        S_PURGE_RUN,
        S_PURGE_END
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_rst_n) begin
                    o_cmd.take_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.op)
                    bdq_pkg::OP_POP_FRONT,
                    bdq_pkg::OP_POP_BACK: begin
                        if (!i_stat.empty) begin
                            o_cmd.pop_read = 1'b1;
                            n_state        = S_POP_DATA;
                        end else if (i_stat.out_free) begin
                            o_cmd.simple_done = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end
                    bdq_pkg::OP_PURGE: begin
                        if (!i_stat.empty) begin
                            o_cmd.purge_read = 1'b1;
                            n_state          = S_PURGE_RUN;
                        end else if (i_stat.out_free) begin
                            o_cmd.simple_done = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            o_cmd.simple_done = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_done = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_PURGE_RUN: begin
                o_cmd.purge_cmp = 1'b1;
                if (i_stat.purge_more) begin
                    o_cmd.purge_read = 1'b1;
                end else begin
                    n_state = S_PURGE_END;
                end
            end
            S_PURGE_END: begin
                if (i_stat.out_free) begin
                    o_cmd.purge_done = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // take a new request only between requests and out of reset
    assign o_req_ready = (r_state == S_IDLE) && i_rst_n;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/bdq_dpath.sv @@
// datapath of the deque: ring memory, front and count, purge walk, output register
module bdq_dpath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bdq_pkg::t_cmd                     i_cmd,
    output bdq_pkg::t_stat                    o_stat,
    input  logic [bdq_pkg::OP_W-1:0]          i_operation,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_value,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [bdq_pkg::DATA_W-1:0] o_popped_value,
    output logic [bdq_pkg::STATUS_W-1:0]      o_status,
    output logic [CNT_W-1:0]                  o_count_after,
    output logic [CNT_W-1:0]                  o_removed_count
);

    localparam int SUM_W = IDX_W + 1;
    localparam int DW    = bdq_pkg::DATA_W;

    // ring memory
    logic [DW-1:0]    r_mem [DEPTH];
    logic [DW-1:0]    r_rdata;

    // queue state
    logic [IDX_W-1:0] r_front;
    logic [CNT_W-1:0] r_count;

    // latched request
    logic [bdq_pkg::OP_W-1:0] r_op;
    logic [DW-1:0]            r_value;

    // purge walk
    logic [IDX_W-1:0] r_rd_ptr;
    logic [IDX_W-1:0] r_wr_ptr;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [CNT_W-1:0] r_wr_cnt;
    logic [CNT_W-1:0] r_removed;

    // output register
    logic                          r_out_valid;
    logic [DW-1:0]                 r_res_pop;
    logic [bdq_pkg::STATUS_W-1:0]  r_res_status;
    logic [CNT_W-1:0]              r_res_count;
    logic [CNT_W-1:0]              r_res_removed;

    // combinational next values
    logic [IDX_W-1:0]             n_front;
    logic [CNT_W-1:0]             n_count;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [DW-1:0]                wr_data;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic                         load;
    logic [DW-1:0]                n_res_pop;
    logic [bdq_pkg::STATUS_W-1:0] n_res_status;
    logic [CNT_W-1:0]             n_res_removed;
    logic                         empty;
    logic                         full;
    logic                         match;
    logic [IDX_W-1:0]             front_dec;
    logic [IDX_W-1:0]             back_slot;
    logic [IDX_W-1:0]             last_slot;
    logic [CNT_W-1:0]             count_dec;

    // fold a sum below twice the depth back into the ring
    function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
        return t[IDX_W-1:0];
    endfunction

    // step one slot forward around the ring
    function automatic logic [IDX_W-1:0] inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : (p + IDX_W'(1));
    endfunction

    assign empty     = (r_count == '0);
    assign full      = (r_count == CNT_W'(DEPTH));
    assign count_dec = r_count - CNT_W'(1);
    assign front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : (r_front - IDX_W'(1));
    assign back_slot = wrap(SUM_W'(r_front) + SUM_W'(r_count));
    assign last_slot = wrap(SUM_W'(r_front) + SUM_W'(count_dec));
    assign match     = (r_rdata == r_value);

    // read port select
    always_comb begin
        rd_en   = i_cmd.pop_read | i_cmd.purge_read;
        rd_addr = r_rd_ptr;
        if (i_cmd.pop_read) begin
            rd_addr = (r_op == bdq_pkg::OP_POP_FRONT) ? r_front : last_slot;
        end
    end

    // request execution, writes and result
    always_comb begin
        n_front       = r_front;
        n_count       = r_count;
        wr_en         = 1'b0;
        wr_addr       = r_wr_ptr;
        wr_data       = r_rdata;
        load          = 1'b0;
        n_res_pop     = '0;
        n_res_status  = bdq_pkg::ST_OK;
        n_res_removed = '0;

        if (i_cmd.simple_done) begin
            load = 1'b1;
            case (r_op)
                bdq_pkg::OP_PUSH_FRONT: begin
                    if (full) begin
                        n_res_status = bdq_pkg::ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = front_dec;
                        wr_data = r_value;
                        n_front = front_dec;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                bdq_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        n_res_status = bdq_pkg::ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = back_slot;
                        wr_data = r_value;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                bdq_pkg::OP_POP_FRONT,
                bdq_pkg::OP_POP_BACK: begin
                    n_res_status = bdq_pkg::ST_EMPTY;
                end
                bdq_pkg::OP_CLEAR: begin
                    n_res_removed = r_count;
                    n_count       = '0;
                    n_front       = '0;
                end
                default: begin
                end
            endcase
        end

        // pop takes the registered read data
        if (i_cmd.pop_done) begin
            load      = 1'b1;
            n_res_pop = r_rdata;
            n_count   = count_dec;
            if (r_op == bdq_pkg::OP_POP_FRONT) begin
                n_front = inc(r_front);
            end
        end

        // survivors are packed toward the front
        if (i_cmd.purge_cmp && !match) begin
            wr_en   = 1'b1;
            wr_addr = r_wr_ptr;
            wr_data = r_rdata;
        end

        if (i_cmd.purge_done) begin
            load          = 1'b1;
            n_count       = r_wr_cnt;
            n_res_removed = r_removed;
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // request latch and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        if (load) begin
            r_res_pop     <= n_res_pop;
            r_res_status  <= n_res_status;
            r_res_count   <= n_count;
            r_res_removed <= n_res_removed;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_rd_cnt    <= '0;
            r_wr_cnt    <= '0;
            r_removed   <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.take_req) begin
                r_rd_ptr  <= r_front;
                r_wr_ptr  <= r_front;
                r_rd_cnt  <= '0;
                r_wr_cnt  <= '0;
                r_removed <= '0;
            end else begin
                if (i_cmd.purge_read) begin
                    r_rd_ptr <= inc(r_rd_ptr);
                    r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                end
                if (i_cmd.purge_cmp) begin
                    if (match) begin
                        r_removed <= r_removed + CNT_W'(1);
                    end else begin
                        r_wr_ptr <= inc(r_wr_ptr);
                        r_wr_cnt <= r_wr_cnt + CNT_W'(1);
                    end
                end
            end
        end
    end

    // status toward the controller
    assign o_stat.op         = r_op;
    assign o_stat.empty      = empty;
    assign o_stat.purge_more = (r_rd_cnt != r_count);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_popped_value  = $signed(r_res_pop);
    assign o_status        = r_res_status;
    assign o_count_after   = r_res_count;
    assign o_removed_count = r_res_removed;

endmodule

@@ dv/bounded_deque_with_value_purge_core_tb.sv @@
// testbench of the bounded deque with value purge: shadow deque predicts every result
module bounded_deque_with_value_purge_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int SLOTS       = DEPTH_DEF;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int POOL_N      = 8;
    localparam int TAIL_CYCLES = 2 * SLOTS + 20;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 50;
    localparam int RUN_LIMIT   = 6_000_000;

    // operation codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [DATA_W-1:0] popped;
        t_status           status;
        logic [CNT_W-1:0]  count_after;
        logic [CNT_W-1:0]  removed;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdq_req_if                  req_if ();
    bdq_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

    bounded_deque_with_value_purge_core #(
        .DEPTH(SLOTS),
        .CNT_W(CNT_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // shadow copy of the deque
    logic [DATA_W-1:0] shadow_ring [SLOTS];
    logic [IDX_W-1:0]  shadow_front = '0;
    int                shadow_count = 0;

    t_outcome          outcomes_due [$];
    logic [DATA_W-1:0] value_pool [POOL_N];
    int                fail_count = 0;
    bit                idle_on = 1'b1;
    int                hold_order = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one request to the shadow deque and return its result
    function automatic t_outcome deque_apply(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
        t_outcome          res;
        int                kept;
        logic [DATA_W-1:0] word;
        res.popped      = '0;
        res.status      = ST_OK;
        res.removed     = '0;
        kept            = 0;
        case (op)
            OP_PUSH_FRONT: begin
                if (shadow_count == SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_front              = shadow_front - 1'b1;
                    shadow_ring[shadow_front] = val;
                    shadow_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (shadow_count == SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_ring[IDX_W'(shadow_front + shadow_count)] = val;
                    shadow_count++;
                end
            end
            OP_POP_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped   = shadow_ring[shadow_front];
                    shadow_front = shadow_front + 1'b1;
                    shadow_count--;
                end
            end
            OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped = shadow_ring[IDX_W'(shadow_front + shadow_count - 1)];
                    shadow_count--;
                end
            end
            OP_PURGE: begin
                // survivors packed toward the front in their old order
                for (int k = 0; k < shadow_count; k++) begin
                    word = shadow_ring[IDX_W'(shadow_front + k)];
                    if (word == val) begin
                        res.removed = res.removed + 1'b1;
                    end else begin
                        shadow_ring[IDX_W'(shadow_front + kept)] = word;
                        kept++;
                    end
                end
                shadow_count = kept;
            end
            OP_CLEAR: begin
                res.removed  = CNT_W'(shadow_count);
                shadow_count = 0;
                shadow_front = '0;
            end
            default: begin
            end
        endcase
        res.count_after = CNT_W'(shadow_count);
        return res;
    endfunction

    // send one request, with an optional idle burst first
    task automatic send_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= val;
        do @(posedge i_clk); while (!req_if.ready);
        outcomes_due.push_back(deque_apply(op, val));
    endtask

    // stop offering and wait until every result is back
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    // mostly values from a small pool so purges find matches
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) begin
            return value_pool[$urandom_range(0, POOL_N - 1)];
        end
        return $urandom();
    endfunction

    // operation mix leaning toward filling or draining
    function automatic logic [OP_W-1:0] pick_op(bit filling);
        int r;
        r = $urandom_range(0, 999);
        if (r < 8) begin
            return r[0] ? OP_SPARE_7 : OP_SPARE_6;
        end else if (r < 100) begin
            return OP_PURGE;
        end else if (!filling && r < 110) begin
            return OP_CLEAR;
        end else if (r < (filling ? 720 : 370)) begin
            return r[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end
        return r[0] ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // edges, empty and unused codes
    task automatic test_directed();
        send_request(OP_POP_FRONT, 32'h1234_5678);
        send_request(OP_POP_BACK, 32'hFFFF_FFFF);
        send_request(OP_PUSH_FRONT, 32'h8000_0000);
        send_request(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(OP_PUSH_FRONT, 32'h0000_0000);
        send_request(OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(OP_POP_FRONT, 32'h0);
        send_request(OP_POP_BACK, 32'h0);
        send_request(OP_PUSH_BACK, 32'h8000_0000);
        send_request(OP_PURGE, 32'h8000_0000);
        send_request(OP_PURGE, 32'h0000_3039);
        send_request(OP_POP_FRONT, 32'h0);
        send_request(OP_PURGE, 32'h7FFF_FFFF);
        send_request(OP_PUSH_FRONT, 32'h0000_0005);
        send_request(OP_PUSH_BACK, 32'hFFFF_FFFE);
        send_request(OP_SPARE_6, 32'hFFFF_FFFF);
        send_request(OP_SPARE_7, 32'h0000_0005);
        send_request(OP_CLEAR, 32'h0000_0005);
        send_request(OP_CLEAR, 32'h0);
        send_request(OP_SPARE_6, 32'h0);
        send_request(OP_PUSH_BACK, 32'h0000_0003);
        send_request(OP_POP_BACK, 32'h0);
        send_request(OP_POP_BACK, 32'h0);
    endtask

    // full queue, pushes refused, purge of a full store, then pops and a clear
    task automatic test_full_queue();
        logic [DATA_W-1:0] same;
        same = value_pool[$urandom_range(0, POOL_N - 1)];
        for (int i = 0; i < SLOTS; i++) send_request(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, same);
        send_request(OP_PUSH_FRONT, pick_value());
        send_request(OP_PUSH_BACK, pick_value());
        send_request(OP_PURGE, same);
        for (int i = 0; i < SLOTS; i++) send_request(i[1] ? OP_PUSH_FRONT : OP_PUSH_BACK,
                                                     pick_value());
        send_request(OP_PUSH_BACK, pick_value());
        send_request(OP_PURGE, value_pool[0]);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_BACK, '0);
        send_request(OP_CLEAR, '0);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_output_hold();
        hold_order = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) send_request(pick_op(i < 25), pick_value());
    endtask

    // sender waits for every result before going on
    task automatic test_drain_pause();
        for (int round = 0; round < 3; round++) begin
            for (int i = 0; i < 15; i++) send_request(pick_op(1'b1), pick_value());
            wait_for_results();
            send_request(OP_PURGE, pick_value());
        end
    endtask

    // random mix swinging between full and empty
    task automatic test_random_mix(int n);
        bit filling;
        filling = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (filling && shadow_count == SLOTS && $urandom_range(0, 7) == 0) begin
                filling = 1'b0;
            end else if (!filling && shadow_count == 0 && $urandom_range(0, 3) == 0) begin
                filling = 1'b1;
            end
            send_request(pick_op(filling), pick_value());
        end
    endtask

    // back to back with no idling on either side
    task automatic test_streaming();
        idle_on = 1'b0;
        test_random_mix(200);
    endtask

    // receiver: long hold on request, otherwise random stall bursts
    initial begin : sink_side
        int hold_left;
        int stall_left;
        hold_left      = 0;
        stall_left     = 0;
        rsp_if.ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_order > 0) begin
                hold_left  = hold_order;
                hold_order = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // compare one result field
    task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_result
        t_outcome want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (outcomes_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: result with no request outstanding, expected none, actual %0h",
                             $time, rsp_if.popped_value);
                end
            end else begin
                want = outcomes_due.pop_front();
                compare_field("popped_value", want.popped, rsp_if.popped_value);
                compare_field("status", DATA_W'(want.status), DATA_W'(rsp_if.status));
                compare_field("count_after", DATA_W'(want.count_after),
                              DATA_W'(rsp_if.count_after));
                compare_field("removed_count", DATA_W'(want.removed),
                              DATA_W'(rsp_if.removed_count));
            end
        end
    end

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // test sequence
    initial begin
        req_if.valid     = 1'b0;
        req_if.operation = OP_PUSH_FRONT;
        req_if.value     = '0;
        i_rst_n          = 1'b0;
        value_pool[0]    = 32'h0000_0000;
        value_pool[1]    = 32'hFFFF_FFFF;
        value_pool[2]    = 32'h8000_0000;
        value_pool[3]    = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_N; i++) value_pool[i] = $urandom();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_queue();
        test_output_hold();
        test_drain_pause();
        test_random_mix(1150);
        test_streaming();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
